// File: rtl/core/atp_pkg.sv
`default_nettype none

package atp_pkg;

  localparam int NOW_W      = 32;
  localparam int DELAY_W    = 16;
  localparam int DUR_W      = 24;
  localparam int COUNT_W    = 16;
  localparam int TOTAL_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [DUR_W-1:0]   DUR_RESET   = DUR_W'(1000);
  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1);

  typedef enum logic [1:0] {
    OP_BEGIN = 2'd0,
    OP_TICK  = 2'd1,
    OP_STOP  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    PH_STOPPED = 2'd0,
    PH_ACTIVE  = 2'd1,
    PH_FILLING = 2'd2
  } phase_t;

  localparam logic [1:0] RM_COUNT   = 2'd0;
  localparam logic [1:0] RM_TOTAL   = 2'd1;
  localparam logic [1:0] RM_FOREVER = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_BEGIN_DELAY  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_DUR     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AUTO_REVERSE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_MODE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_COUNT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_TOTAL = 3'd5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_DIV,
    S_MUL,
    S_OUT
  } seq_state_t;

  // Status of a serial arithmetic unit.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/atp_div.sv
`default_nettype none

module atp_div #(
  parameter int NUM_W  = 32,
  parameter int FRAC_W = 16,
  parameter int DEN_W  = 24
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [NUM_W-1:0]  num,
  input  wire logic [DEN_W-1:0]  den,
  output atp_pkg::unit_stat_t    stat,
  output logic      [FRAC_W:0]   quo
);
  import atp_pkg::*;

  localparam int STEPS = NUM_W + FRAC_W;
  localparam int CNT_W = $clog2(STEPS);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] num_sh;
  logic [DEN_W-1:0] rem;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;
  logic [DEN_W-1:0] rem_next;

  // Restoring division of num * 2^FRAC_W by den, one quotient bit a cycle.
  // Once the numerator bits run out, zeros shift in to form the fraction.
  always_comb begin
    trial    = {rem, num_sh[NUM_W-1]};
    fits     = trial >= {1'b0, den};
    diff     = trial - {1'b0, den};
    rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(STEPS - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_sh <= num;
      rem    <= '0;
    end else if (busy) begin
      num_sh <= {num_sh[NUM_W-2:0], 1'b0};
      rem    <= rem_next;
      quo    <= {quo[FRAC_W-1:0], fits};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

`default_nettype wire

// File: rtl/core/atp_mul.sv
`default_nettype none

module atp_mul #(
  parameter int A_W = 16,
  parameter int B_W = 24
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [A_W-1:0]       a,
  input  wire logic [B_W-1:0]       b,
  output atp_pkg::unit_stat_t       stat,
  output logic      [A_W+B_W-1:0]   prod
);
  import atp_pkg::*;

  localparam int CNT_W = $clog2(A_W);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [A_W-1:0]   a_sh;
  logic [B_W-1:0]   b_r;
  logic [B_W:0]     sum;

  // Shift-add, multiplier bits taken LSB first; the accumulator shifts right
  // so the adder stays as wide as the multiplicand.
  always_comb begin
    sum = (B_W+1)'(prod[A_W+B_W-1:A_W]) + (B_W+1)'(a_sh[0] ? b_r : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(A_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_sh <= a;
      b_r  <= b;
      prod <= '0;
    end else if (busy) begin
      a_sh <= a_sh >> 1;
      prod <= {sum, prod[A_W-1:1]};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

`default_nettype wire

// File: rtl/core/animation_timeline_progress_unit.sv
// Each item runs the bit-serial divider and then the serial multiplier for the current time.
// One item is in work at a time; the input stalls until the result is loaded into the output
// register. Reset is synchronous and active high; it restores the register defaults, stops the
// timeline and empties the output register.
`default_nettype none

module animation_timeline_progress_unit #(
  parameter int TIME_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [1:0]                       operation,
  input  wire logic [atp_pkg::NOW_W-1:0]        now_ms,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic      [FRAC_BITS:0]               progress_q16,
  output logic      [atp_pkg::DUR_W-1:0]        current_time_ms,
  output logic      [1:0]                       run_state,
  output logic                                  processing,
  output logic                                  completed,
  output logic                                  state_changed,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [atp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [atp_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import atp_pkg::*;

  localparam int TW     = (TIME_BITS < NOW_W) ? TIME_BITS : NOW_W;
  localparam int F      = FRAC_BITS;
  localparam int LOOP_W = DUR_W + 1;
  localparam int LEN_W  = COUNT_W + LOOP_W;
  localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

  // Configuration registers.
  logic [DELAY_W-1:0] begin_delay;
  logic [DUR_W-1:0]   loop_dur;
  logic               auto_rev;
  logic [1:0]         repeat_mode;
  logic [COUNT_W-1:0] repeat_count;
  logic [TOTAL_W-1:0] repeat_total;

  // Timeline state.
  logic [TW:0]  start_time;
  logic         started;
  phase_t       phase;
  logic         ticking;

  // Item in work.
  logic [1:0]   op_r;
  logic [TW-1:0] now_r;
  logic [TW-1:0] elapsed_r;
  logic         late_r;
  logic         ok_r;
  logic         exact_r;
  logic [F:0]   prog_r;
  logic         proc_r;
  logic         comp_r;
  logic         chg_r;

  seq_state_t   state;
  seq_state_t   state_next;

  logic         in_acc;
  logic         out_load;
  logic         calc_start;
  logic         cur_start;

  logic         late;
  logic [TW-1:0] elapsed;

  logic [LOOP_W-1:0]   one_loop;
  logic [LEN_W-1:0]    len_prod;
  logic [LEN_W-1:0]    len;
  logic                finite;
  logic [F:0]          quo;
  logic [F:0]          p_fwd;
  logic [F:0]          prog_next;
  logic [F+DUR_W:0]    cur_prod;
  unit_stat_t          div_stat;
  unit_stat_t          len_stat;
  unit_stat_t          cur_stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      begin_delay  <= '0;
      loop_dur     <= DUR_RESET;
      auto_rev     <= 1'b0;
      repeat_mode  <= RM_COUNT;
      repeat_count <= COUNT_RESET;
      repeat_total <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_BEGIN_DELAY:  begin_delay  <= cfg_data[DELAY_W-1:0];
        CFG_LOOP_DUR:     loop_dur     <= cfg_data[DUR_W-1:0];
        CFG_AUTO_REVERSE: auto_rev     <= cfg_data[0];
        CFG_REPEAT_MODE:  repeat_mode  <= cfg_data[1:0];
        CFG_REPEAT_COUNT: repeat_count <= cfg_data[COUNT_W-1:0];
        CFG_REPEAT_TOTAL: repeat_total <= cfg_data[TOTAL_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_LOAD;
      S_LOAD: state_next = S_DIV;
      S_DIV:  if (div_stat.done) state_next = S_MUL;
      S_MUL:  if (cur_stat.done) state_next = S_OUT;
      S_OUT:  if (!out_valid || !out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = (state != S_IDLE);
    calc_start = (state == S_LOAD);
    cur_start  = (state == S_DIV) && div_stat.done;
    out_load   = (state == S_OUT) && (!out_valid || !out_stall);
  end

  assign in_acc = in_valid && !in_stall;

  // Elapsed time since start; only meaningful once the start time has passed.
  always_comb begin
    late    = started && ({1'b0, now_r} >= start_time);
    elapsed = now_r - start_time[TW-1:0];
  end

  // The length multiply finishes well before the divider, so its product is
  // ready when the tick is decided at the end of the division.
  assign one_loop = auto_rev ? {loop_dur, 1'b0} : {1'b0, loop_dur};

  atp_mul #(.A_W(COUNT_W), .B_W(LOOP_W)) u_len_mul (
    .clk   (clk),
    .rst   (rst),
    .start (calc_start),
    .a     (repeat_count),
    .b     (one_loop),
    .stat  (len_stat),
    .prod  (len_prod)
  );

  atp_div #(.NUM_W(TW), .FRAC_W(F), .DEN_W(DUR_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (calc_start),
    .num   (elapsed),
    .den   (loop_dur),
    .stat  (div_stat),
    .quo   (quo)
  );

  atp_mul #(.A_W(F + 1), .B_W(DUR_W)) u_cur_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cur_start),
    .a     (prog_next),
    .b     (loop_dur),
    .stat  (cur_stat),
    .prod  (cur_prod)
  );

  always_comb begin
    finite = (repeat_mode == RM_COUNT) || (repeat_mode == RM_TOTAL);
    len    = (repeat_mode == RM_COUNT) ? len_prod : LEN_W'(repeat_total);
    p_fwd  = {1'b0, quo[F-1:0]};
    // The quotient bit above the fraction is the parity of the loop number.
    priority if (!ok_r) begin
      prog_next = '0;
    end else if (exact_r) begin
      prog_next = ONE;
    end else if (auto_rev && quo[F]) begin
      prog_next = ONE - p_fwd;
    end else begin
      prog_next = p_fwd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_time <= '0;
      started    <= 1'b0;
      phase      <= PH_STOPPED;
      ticking    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_acc) begin
        unique case (operation)
          OP_BEGIN: begin
            start_time <= {1'b0, now_ms[TW-1:0]} + (TW+1)'(begin_delay);
            started    <= 1'b1;
            phase      <= PH_ACTIVE;
            ticking    <= 1'b1;
          end
          OP_STOP: ticking <= 1'b0;
          default: ;
        endcase
      end
      if (cur_start && (op_r == OP_TICK) && ticking && late_r && finite &&
          (LEN_W'(elapsed_r) >= len)) begin
        ticking <= 1'b0;
        phase   <= PH_FILLING;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= operation;
      now_r  <= now_ms[TW-1:0];
      chg_r  <= (operation == OP_BEGIN);
      proc_r <= 1'b0;
      comp_r <= 1'b0;
    end
    if (calc_start) begin
      late_r    <= late;
      elapsed_r <= elapsed;
      ok_r      <= late && (loop_dur != '0);
      exact_r   <= ((TW+DUR_W)'(elapsed) == (TW+DUR_W)'(loop_dur));
    end
    if (cur_start) begin
      prog_r <= prog_next;
      if ((op_r == OP_TICK) && ticking && late_r) begin
        proc_r <= !finite || (len != '0);
        if (finite && (LEN_W'(elapsed_r) >= len)) begin
          comp_r <= 1'b1;
          chg_r  <= 1'b1;
        end
      end
    end
    if (out_load) begin
      progress_q16    <= prog_r;
      current_time_ms <= cur_prod[F+DUR_W-1:F];
      run_state       <= phase;
      processing      <= proc_r;
      completed       <= comp_r;
      state_changed   <= chg_r;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/atp_chk.sv
`default_nettype none

module atp_chk #(
  parameter int FRAC_BITS = 16
) (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 in_valid,
  input wire logic                 in_stall,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire logic [FRAC_BITS:0]   progress_q16,
  input wire logic [1:0]           run_state,
  input wire logic                 processing,
  input wire logic                 completed,
  input wire logic                 state_changed
);
  import atp_pkg::*;

  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // One item at a time: the input closes right after an accept.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while an item is in work");

  a_progress_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (progress_q16 <= ONE))
    else $error("progress above one");

  a_complete_fills: assert property (@(posedge clk) disable iff (rst)
    (out_valid && completed) |-> (state_changed && (run_state == PH_FILLING)))
    else $error("completion without the filling state");

  a_change_not_stopped: assert property (@(posedge clk) disable iff (rst)
    (out_valid && state_changed) |-> (run_state != PH_STOPPED))
    else $error("state change reported into stopped");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(progress_q16) &&
                                  $stable(processing)))
    else $error("stalled result changed");

endmodule

bind animation_timeline_progress_unit atp_chk #(.FRAC_BITS(FRAC_BITS)) u_atp_chk (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .progress_q16  (progress_q16),
  .run_state     (run_state),
  .processing    (processing),
  .completed     (completed),
  .state_changed (state_changed)
);

`default_nettype wire
